// ===== hdl/width_signed_int_divider_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the width-selectable signed integer divider.
// ----------------------------------------------------------------------------
`ifndef WIDTH_SIGNED_INT_DIVIDER_DEFINES_SVH
`define WIDTH_SIGNED_INT_DIVIDER_DEFINES_SVH

// Checks that a condition implies a second one in the same cycle.
`define WSID_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a condition is followed by a second one after the delay given by dly.
`define WSID_ASSERT_DELAYED(lbl, clk, rstn, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> ##(dly) (cons)) \
    else $error(msg);

`endif

// ===== hdl/wsid_pkg.sv =====
// ----------------------------------------------------------------------------
// wsid_pkg
// Shared types, codes and helpers of the width-selectable integer divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wsid_pkg;

  // Width of the payload data fields and of the operand width field.
  localparam int DATA_W  = 64;
  localparam int WIDTH_W = 7;

  // Command codes of a request.
  typedef enum logic {
    CMD_QUO = 1'b0,
    CMD_REM = 1'b1
  } cmd_t;

  // Error codes of a result.
  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_DIV_ZERO = 2'd1,
    ERR_OVERFLOW = 2'd2
  } err_t;

  // Control group that travels with each request down the pipeline.
  typedef struct packed {
    logic               valid;
    cmd_t               cmd;
    logic               neg_quo;
    logic               neg_rem;
    err_t               err;
    logic [WIDTH_W-1:0] width;
  } ctrl_t;

  // Mask with the low w bits set; w at or above DATA_W gives all ones.
  function automatic logic [DATA_W-1:0] width_mask(input logic [WIDTH_W-1:0] w);
    width_mask = ~({DATA_W{1'b1}} << w);
  endfunction

endpackage

// ===== hdl/wsid_prep.sv =====
// ----------------------------------------------------------------------------
// wsid_prep
// Input stage: clamps the width, masks the operands, flags the error cases
// and takes the magnitudes of signed operands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wsid_prep #(
  parameter int MAX_WIDTH = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        req_valid,
  input  logic                        command,
  input  logic [MAX_WIDTH-1:0]        dividend,
  input  logic [MAX_WIDTH-1:0]        divisor_bits,
  input  logic [wsid_pkg::WIDTH_W-1:0] op_width,
  input  logic                        is_signed,
  output wsid_pkg::ctrl_t             ctrl_o,
  output logic [MAX_WIDTH-1:0]        num_o,
  output logic [MAX_WIDTH-1:0]        den_o
);

  logic [wsid_pkg::WIDTH_W-1:0] width_c;
  logic [wsid_pkg::DATA_W-1:0]  mask_full;
  logic [MAX_WIDTH-1:0]         mask;
  logic [MAX_WIDTH-1:0]         sbit;
  logic [MAX_WIDTH-1:0]         a;
  logic [MAX_WIDTH-1:0]         b;
  logic                         a_neg;
  logic                         b_neg;
  wsid_pkg::ctrl_t              ctrl_r;
  wsid_pkg::ctrl_t              ctrl_nxt;
  logic [MAX_WIDTH-1:0]         num_r;
  logic [MAX_WIDTH-1:0]         num_nxt;
  logic [MAX_WIDTH-1:0]         den_r;
  logic [MAX_WIDTH-1:0]         den_nxt;

  // Clamp the operand width to the range 1 .. MAX_WIDTH.
  always_comb begin
    if (op_width == '0) begin
      width_c = wsid_pkg::WIDTH_W'(1);
    end else if (op_width > wsid_pkg::WIDTH_W'(MAX_WIDTH)) begin
      width_c = wsid_pkg::WIDTH_W'(MAX_WIDTH);
    end else begin
      width_c = op_width;
    end
  end

  // Mask the operands and find the sign bit position.
  assign mask_full = wsid_pkg::width_mask(width_c);
  assign mask      = mask_full[MAX_WIDTH-1:0];
  assign sbit      = MAX_WIDTH'(1) << (width_c - wsid_pkg::WIDTH_W'(1));
  assign a         = dividend & mask;
  assign b         = divisor_bits & mask;
  assign a_neg     = is_signed && ((a & sbit) != '0);
  assign b_neg     = is_signed && ((b & sbit) != '0);

  // Build the control group and the unsigned magnitudes.
  always_comb begin
    ctrl_nxt.valid   = req_valid;
    ctrl_nxt.cmd     = wsid_pkg::cmd_t'(command);
    ctrl_nxt.neg_quo = a_neg ^ b_neg;
    ctrl_nxt.neg_rem = a_neg;
    ctrl_nxt.width   = width_c;
    if (b == '0) begin
      ctrl_nxt.err = wsid_pkg::ERR_DIV_ZERO;
    end else if (is_signed && (a == sbit) && (b == mask)) begin
      ctrl_nxt.err = wsid_pkg::ERR_OVERFLOW;
    end else begin
      ctrl_nxt.err = wsid_pkg::ERR_NONE;
    end
    num_nxt = a_neg ? ((~a + MAX_WIDTH'(1)) & mask) : a;
    den_nxt = b_neg ? ((~b + MAX_WIDTH'(1)) & mask) : b;
  end

  // Stage register; only the control group is reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else begin
      ctrl_r <= ctrl_nxt;
    end
    num_r <= num_nxt;
    den_r <= den_nxt;
  end

  assign ctrl_o = ctrl_r;
  assign num_o  = num_r;
  assign den_o  = den_r;

endmodule

// ===== hdl/wsid_cell.sv =====
// ----------------------------------------------------------------------------
// wsid_cell
// One restoring division step: shifts the next dividend bit into the partial
// remainder, subtracts the divisor when it fits and records the quotient bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wsid_cell #(
  parameter int MAX_WIDTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  wsid_pkg::ctrl_t      ctrl_i,
  input  logic [MAX_WIDTH-1:0] rem_i,
  input  logic [MAX_WIDTH-1:0] quo_i,
  input  logic [MAX_WIDTH-1:0] den_i,
  output wsid_pkg::ctrl_t      ctrl_o,
  output logic [MAX_WIDTH-1:0] rem_o,
  output logic [MAX_WIDTH-1:0] quo_o,
  output logic [MAX_WIDTH-1:0] den_o
);

  logic [MAX_WIDTH:0]   shifted;
  logic [MAX_WIDTH:0]   diff;
  wsid_pkg::ctrl_t      ctrl_r;
  logic [MAX_WIDTH-1:0] rem_r;
  logic [MAX_WIDTH-1:0] rem_nxt;
  logic [MAX_WIDTH-1:0] quo_r;
  logic [MAX_WIDTH-1:0] quo_nxt;
  logic [MAX_WIDTH-1:0] den_r;

  // Trial subtraction; a clear top bit means the divisor fits.
  assign shifted = {rem_i, quo_i[MAX_WIDTH-1]};
  assign diff    = shifted - {1'b0, den_i};

  always_comb begin
    if (!diff[MAX_WIDTH]) begin
      rem_nxt = diff[MAX_WIDTH-1:0];
      quo_nxt = {quo_i[MAX_WIDTH-2:0], 1'b1};
    end else begin
      rem_nxt = shifted[MAX_WIDTH-1:0];
      quo_nxt = {quo_i[MAX_WIDTH-2:0], 1'b0};
    end
  end

  // Hand the step result to the next cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else begin
      ctrl_r <= ctrl_i;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_i;
  end

  assign ctrl_o = ctrl_r;
  assign rem_o  = rem_r;
  assign quo_o  = quo_r;
  assign den_o  = den_r;

endmodule

// ===== hdl/wsid_post.sv =====
// ----------------------------------------------------------------------------
// wsid_post
// Output stage: selects quotient or remainder, restores the sign, masks the
// result to the operand width and forces zero on error.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wsid_post #(
  parameter int MAX_WIDTH = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  wsid_pkg::ctrl_t             ctrl_i,
  input  logic [MAX_WIDTH-1:0]        rem_i,
  input  logic [MAX_WIDTH-1:0]        quo_i,
  output logic                        valid_o,
  output logic [wsid_pkg::DATA_W-1:0] result_o,
  output wsid_pkg::err_t              error_o
);

  logic [MAX_WIDTH-1:0]        mag;
  logic                        neg;
  logic [MAX_WIDTH-1:0]        signed_val;
  logic [wsid_pkg::DATA_W-1:0] mask_full;
  logic [MAX_WIDTH-1:0]        mask;
  logic                        valid_r;
  logic [wsid_pkg::DATA_W-1:0] result_r;
  logic [wsid_pkg::DATA_W-1:0] result_nxt;
  wsid_pkg::err_t              error_r;

  // Pick the requested value and its sign.
  always_comb begin
    if (ctrl_i.cmd == wsid_pkg::CMD_REM) begin
      mag = rem_i;
      neg = ctrl_i.neg_rem;
    end else begin
      mag = quo_i;
      neg = ctrl_i.neg_quo;
    end
  end

  // Negate, mask and zero on error.
  assign signed_val = neg ? (~mag + MAX_WIDTH'(1)) : mag;
  assign mask_full  = wsid_pkg::width_mask(ctrl_i.width);
  assign mask       = mask_full[MAX_WIDTH-1:0];
  assign result_nxt = (ctrl_i.err != wsid_pkg::ERR_NONE) ? '0 :
                      wsid_pkg::DATA_W'(signed_val & mask);

  // Output register; the strobe is reset, the payload is not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctrl_i.valid;
    end
    result_r <= result_nxt;
    error_r  <= ctrl_i.err;
  end

  assign valid_o  = valid_r;
  assign result_o = result_r;
  assign error_o  = error_r;

endmodule

// ===== hdl/width_signed_int_divider.sv =====
// ----------------------------------------------------------------------------
// Pipeline: input stage, MAX_WIDTH step cells and output stage, each registered, up to out_valid.
// Throughput: one request per cycle outside of reset, as the chain of MAX_WIDTH step cells is pipelined.
// Reset: synchronous, active low; clears all valid flags, busy is high in reset.
// Results are strobed for one cycle and the receiver cannot stall them.
// ----------------------------------------------------------------------------
// width_signed_int_divider
// Signed or unsigned divider with a selectable operand width, built as an
// input stage, a chain of restoring division cells and an output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "width_signed_int_divider_defines.svh"

module width_signed_int_divider #(
  parameter int MAX_WIDTH = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_command,
  input  logic [wsid_pkg::DATA_W-1:0] in_dividend,
  input  logic [wsid_pkg::DATA_W-1:0] in_divisor_bits,
  input  logic [wsid_pkg::WIDTH_W-1:0] in_op_width,
  input  logic                        in_is_signed,
  output logic                        out_valid,
  output logic [wsid_pkg::DATA_W-1:0] out_result,
  output logic [1:0]                  out_error
);

  localparam int LATENCY = MAX_WIDTH + 2;

  wsid_pkg::ctrl_t      ctrl_s [0:MAX_WIDTH];
  logic [MAX_WIDTH-1:0] rem_s  [0:MAX_WIDTH];
  logic [MAX_WIDTH-1:0] quo_s  [0:MAX_WIDTH];
  logic [MAX_WIDTH-1:0] den_s  [0:MAX_WIDTH];
  wsid_pkg::err_t       err_w;
  logic                 req_acc;
  logic                 err_known;
  logic                 err_flag;

  // A new request is taken every cycle outside of reset.
  assign busy    = !rst_n;
  assign req_acc = start && !busy;

  // Input stage.
  wsid_prep #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_prep (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req_acc),
    .command     (in_command),
    .dividend    (in_dividend[MAX_WIDTH-1:0]),
    .divisor_bits(in_divisor_bits[MAX_WIDTH-1:0]),
    .op_width    (in_op_width),
    .is_signed   (in_is_signed),
    .ctrl_o      (ctrl_s[0]),
    .num_o       (quo_s[0]),
    .den_o       (den_s[0])
  );

  // The partial remainder starts at zero.
  assign rem_s[0] = '0;

  // Chain of division cells, one quotient bit per cell.
  for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_cell
    wsid_cell #(
      .MAX_WIDTH(MAX_WIDTH)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl_i(ctrl_s[i]),
      .rem_i (rem_s[i]),
      .quo_i (quo_s[i]),
      .den_i (den_s[i]),
      .ctrl_o(ctrl_s[i+1]),
      .rem_o (rem_s[i+1]),
      .quo_o (quo_s[i+1]),
      .den_o (den_s[i+1])
    );
  end

  // Output stage.
  wsid_post #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_post (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl_i  (ctrl_s[MAX_WIDTH]),
    .rem_i   (rem_s[MAX_WIDTH]),
    .quo_i   (quo_s[MAX_WIDTH]),
    .valid_o (out_valid),
    .result_o(out_result),
    .error_o (err_w)
  );

  assign out_error = err_w;

  // Terms checked by the assertions below.
  assign err_known = (out_error == wsid_pkg::ERR_NONE) ||
                     (out_error == wsid_pkg::ERR_DIV_ZERO) ||
                     (out_error == wsid_pkg::ERR_OVERFLOW);
  assign err_flag  = out_valid && (out_error != wsid_pkg::ERR_NONE);

  // Every accepted request produces its result on out_valid.
  `WSID_ASSERT_DELAYED(a_latency, clk, rst_n, req_acc, LATENCY, out_valid, "result missing")

  // No result appears without an earlier accepted request.
  `WSID_ASSERT_IMPLIES(a_no_spurious, clk, rst_n, out_valid, $past(req_acc, LATENCY), "no request")

  // Error codes stay within the defined set.
  `WSID_ASSERT_IMPLIES(a_err_code, clk, rst_n, out_valid, err_known, "undefined error code")

  // A flagged error always comes with a zero result.
  `WSID_ASSERT_IMPLIES(a_err_zero, clk, rst_n, err_flag, out_result == '0, "nonzero on error")

endmodule

// ===== test/width_signed_int_divider_tb.sv =====
// ----------------------------------------------------------------------------
// width_signed_int_divider_tb
// Self-checking testbench for the width-selectable signed integer divider.
// Requests go in over the start/busy handshake with random gaps. Every
// accepted request is run through a local model of the division, and the
// answer is queued. Each out_valid strobe is compared with the oldest queued
// answer. Directed corner cases come first, then random requests over
// all widths, signedness and commands, then a batch aimed at the error paths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module width_signed_int_divider_tb;

  localparam int MAX_W      = 64;
  localparam int LATENCY    = MAX_W + 2;
  localparam int RAND_ITEMS = 1380;
  localparam int ERR_ITEMS  = 100;

  // Expected answer of one division request.
  typedef struct {
    logic [wsid_pkg::DATA_W-1:0] quo_rem;
    wsid_pkg::err_t              err;
  } answer_t;

  logic                         clk;
  logic                         rst_n;
  logic                         start;
  logic                         busy;
  logic                         in_command;
  logic [wsid_pkg::DATA_W-1:0]  in_dividend;
  logic [wsid_pkg::DATA_W-1:0]  in_divisor_bits;
  logic [wsid_pkg::WIDTH_W-1:0] in_op_width;
  logic                         in_is_signed;
  logic                         out_valid;
  logic [wsid_pkg::DATA_W-1:0]  out_result;
  logic [1:0]                   out_error;

  answer_t pending_answers[$];
  int      fail_count = 0;
  bit      no_gaps    = 1'b0;

  width_signed_int_divider #(
    .MAX_WIDTH(MAX_W)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_dividend     (in_dividend),
    .in_divisor_bits (in_divisor_bits),
    .in_op_width     (in_op_width),
    .in_is_signed    (in_is_signed),
    .out_valid       (out_valid),
    .out_result      (out_result),
    .out_error       (out_error)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Computes the quotient or remainder that the divider must return.
  function automatic answer_t predict_division(wsid_pkg::cmd_t cmd,
                                               logic [wsid_pkg::DATA_W-1:0] dvd,
                                               logic [wsid_pkg::DATA_W-1:0] dvs,
                                               logic [wsid_pkg::WIDTH_W-1:0] wfield,
                                               logic sgn);
    answer_t                     ans;
    int unsigned                 w;
    logic [wsid_pkg::DATA_W-1:0] mask, a, b, sbit, ua, ub, r;
    logic                        aneg, bneg;
    w = wfield;
    if (w == 0) w = 1;
    if (w > MAX_W) w = MAX_W;
    mask = (w >= wsid_pkg::DATA_W) ? '1 : ((64'd1 << w) - 64'd1);
    a    = dvd & mask;
    b    = dvs & mask;
    sbit = 64'd1 << (w - 1);
    ans.quo_rem = '0;
    ans.err     = wsid_pkg::ERR_NONE;
    if (b == '0) begin
      ans.err = wsid_pkg::ERR_DIV_ZERO;
    end else if (sgn && a == sbit && b == mask) begin
      ans.err = wsid_pkg::ERR_OVERFLOW;
    end else begin
      aneg = sgn && ((a & sbit) != '0);
      bneg = sgn && ((b & sbit) != '0);
      ua   = aneg ? ((-a) & mask) : a;
      ub   = bneg ? ((-b) & mask) : b;
      if (cmd == wsid_pkg::CMD_QUO) begin
        r = ua / ub;
        if (aneg != bneg) r = -r;
      end else begin
        r = ua % ub;
        if (aneg) r = -r;
      end
      ans.quo_rem = r & mask;
    end
    return ans;
  endfunction

  // Draws an operand that often sits on a boundary of the given width, with
  // random junk above the width that the divider must ignore.
  function automatic logic [wsid_pkg::DATA_W-1:0] pick_operand(int unsigned wfield);
    int unsigned                 w;
    logic [wsid_pkg::DATA_W-1:0] mask, sbit, v;
    w = (wfield == 0) ? 1 : ((wfield > MAX_W) ? MAX_W : wfield);
    mask = (w >= wsid_pkg::DATA_W) ? '1 : ((64'd1 << w) - 64'd1);
    sbit = 64'd1 << (w - 1);
    case ($urandom_range(0, 11))
      0:       v = '0;
      1:       v = 64'd1;
      2:       v = mask;
      3:       v = sbit;
      4:       v = sbit - 64'd1;
      5:       v = 64'($urandom_range(0, 15));
      6:       v = sbit + 64'($urandom_range(0, 7));
      7:       v = mask - 64'($urandom_range(0, 7));
      default: v = {$urandom, $urandom};
    endcase
    return (v & mask) | ({$urandom, $urandom} & ~mask);
  endfunction

  // Draws an operand width, mostly legal, sometimes zero or above the maximum.
  function automatic logic [wsid_pkg::WIDTH_W-1:0] pick_width();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return wsid_pkg::WIDTH_W'($urandom_range(MAX_W + 1, 127));
      2:       return wsid_pkg::WIDTH_W'(MAX_W);
      3:       return wsid_pkg::WIDTH_W'(1);
      4, 5, 6: return wsid_pkg::WIDTH_W'($urandom_range(2, 8));
      default: return wsid_pkg::WIDTH_W'($urandom_range(1, MAX_W));
    endcase
  endfunction

  // Sends one request and queues its answer once the divider takes it.
  task automatic issue_division(wsid_pkg::cmd_t cmd, logic [wsid_pkg::DATA_W-1:0] dvd,
                                logic [wsid_pkg::DATA_W-1:0] dvs,
                                logic [wsid_pkg::WIDTH_W-1:0] wfield, logic sgn);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    in_command      <= cmd;
    in_dividend     <= dvd;
    in_divisor_bits <= dvs;
    in_op_width     <= wfield;
    in_is_signed    <= sgn;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_answers.push_back(predict_division(cmd, dvd, dvs, wfield, sgn));
  endtask

  // Compares every strobed result with the oldest queued answer.
  always @(posedge clk) begin
    answer_t exp_ans;
    if (rst_n && out_valid) begin
      if (pending_answers.size() == 0) begin
        $error("result strobed with no request outstanding: result=%h error=%0d",
               out_result, out_error);
        fail_count++;
      end else begin
        exp_ans = pending_answers.pop_front();
        if (out_result !== exp_ans.quo_rem) begin
          $error("result mismatch: expected %h, actual %h", exp_ans.quo_rem, out_result);
          fail_count++;
        end
        if (out_error !== exp_ans.err) begin
          $error("error mismatch: expected %0d, actual %0d", exp_ans.err, out_error);
          fail_count++;
        end
      end
    end
  end

  // Boundary values, every command and each special case.
  task automatic test_corner_cases();
    issue_division(wsid_pkg::CMD_QUO, 64'd100, 64'd0, 7'd64, 1'b0);
    issue_division(wsid_pkg::CMD_REM, 64'd100, 64'hFFFF_FFFF_0000_0000, 7'd32, 1'b1);
    issue_division(wsid_pkg::CMD_QUO, 64'h8000_0000_0000_0000, '1, 7'd64, 1'b1);
    issue_division(wsid_pkg::CMD_REM, 64'h8000_0000_0000_0000, '1, 7'd64, 1'b1);
    issue_division(wsid_pkg::CMD_QUO, 64'hFFFF_FF80, 64'h00FF, 7'd8, 1'b1);
    issue_division(wsid_pkg::CMD_QUO, 64'h8000_0000_0000_0000, '1, 7'd64, 1'b0);
    issue_division(wsid_pkg::CMD_QUO, '1, 64'd1, 7'd64, 1'b0);
    issue_division(wsid_pkg::CMD_REM, '1, 64'd7, 7'd64, 1'b0);
    issue_division(wsid_pkg::CMD_QUO, 64'hFFFF_FFFF_FFFF_FFF9, 64'd2, 7'd64, 1'b1);
    issue_division(wsid_pkg::CMD_REM, 64'hFFFF_FFFF_FFFF_FFF9, 64'd2, 7'd64, 1'b1);
    issue_division(wsid_pkg::CMD_QUO, 64'd7, 64'hFFFF_FFFF_FFFF_FFFE, 7'd64, 1'b1);
    issue_division(wsid_pkg::CMD_REM, 64'd7, 64'hFFFF_FFFF_FFFF_FFFE, 7'd64, 1'b1);
    issue_division(wsid_pkg::CMD_QUO, 64'hF9, 64'hFE, 7'd8, 1'b1);
    issue_division(wsid_pkg::CMD_REM, 64'hF9, 64'hFE, 7'd8, 1'b1);
    // Width zero behaves like width one.
    issue_division(wsid_pkg::CMD_QUO, 64'd1, 64'd1, 7'd0, 1'b0);
    issue_division(wsid_pkg::CMD_QUO, 64'd1, 64'd1, 7'd0, 1'b1);
    issue_division(wsid_pkg::CMD_REM, 64'd0, 64'd1, 7'd1, 1'b1);
    // Widths above the maximum behave like the maximum.
    issue_division(wsid_pkg::CMD_QUO, '1, 64'd3, 7'd127, 1'b0);
    issue_division(wsid_pkg::CMD_REM, '1, 64'd3, 7'd65, 1'b1);
    issue_division(wsid_pkg::CMD_QUO, 64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF,
                   7'd64, 1'b1);
    issue_division(wsid_pkg::CMD_QUO, 64'hAAAA_0000_0000_0003, 64'h5555_0000_0000_0002,
                   7'd16, 1'b0);
    issue_division(wsid_pkg::CMD_REM, '0, '1, 7'd64, 1'b0);
  endtask

  // Random requests across widths, signedness and commands, with runs
  // of back-to-back requests mixed in.
  task automatic test_random_divisions();
    logic [wsid_pkg::WIDTH_W-1:0] wfield;
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      wfield = pick_width();
      issue_division(wsid_pkg::cmd_t'($urandom_range(0, 1)), pick_operand(wfield),
                     pick_operand(wfield), wfield, 1'($urandom_range(0, 1)));
    end
    no_gaps = 1'b0;
  endtask

  // Random requests that hit a zero divisor or the signed overflow.
  task automatic test_error_cases();
    logic [wsid_pkg::WIDTH_W-1:0] wfield;
    logic [wsid_pkg::DATA_W-1:0]  mask, junk;
    int unsigned                  w;
    for (int i = 0; i < ERR_ITEMS; i++) begin
      wfield = pick_width();
      w      = (wfield == 0) ? 1 : ((wfield > MAX_W) ? MAX_W : wfield);
      mask   = (w >= wsid_pkg::DATA_W) ? '1 : ((64'd1 << w) - 64'd1);
      junk   = {$urandom, $urandom} & ~mask;
      if ($urandom_range(0, 1)) begin
        issue_division(wsid_pkg::cmd_t'($urandom_range(0, 1)), pick_operand(wfield), junk,
                       wfield, 1'($urandom_range(0, 1)));
      end else begin
        issue_division(wsid_pkg::cmd_t'($urandom_range(0, 1)), (64'd1 << (w - 1)) | junk,
                       mask | ({$urandom, $urandom} & ~mask), wfield, 1'b1);
      end
    end
  endtask

  // Main sequence: reset, tests in turn, drain, verdict.
  initial begin
    rst_n           <= 1'b0;
    start           <= 1'b0;
    in_command      <= wsid_pkg::CMD_QUO;
    in_dividend     <= '0;
    in_divisor_bits <= '0;
    in_op_width     <= 7'd1;
    in_is_signed    <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_corner_cases();
    test_random_divisions();
    test_error_cases();

    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
